### rtl/f9csm_pkg.sv
// shared types, constants and register codes of the fast-9 corner score map
package f9csm_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = 11;
	localparam int ROW_W     = 16;
	localparam int PIX_W     = 8;
	localparam int FW_W      = 12;
	localparam int WIN       = 7;
	localparam int LINES     = WIN - 1;
	localparam int LINE_W    = LINES * PIX_W;
	localparam int RING_N    = 16;
	localparam int ARC_LEN   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [PIX_W-1:0] NO_CORNER = 8'hFF;

	// bresenham circle of radius 3 around the centre, clockwise from the top
	localparam int RING_DX [RING_N] = '{ 0,  1,  2,  3,  3,  3,  2,  1,
	                                     0, -1, -2, -3, -3, -3, -2, -1};
	localparam int RING_DY [RING_N] = '{-3, -3, -2, -1,  0,  1,  2,  3,
	                                     3,  3,  2,  1,  0, -1, -2, -3};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD    = 2'd2
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	// [row][col], row 0 oldest, col 6 newest
	typedef pix_t [WIN-1:0][WIN-1:0] win_t;

	typedef struct packed {
		logic [COL_W-1:0] map_x;
		logic [ROW_W-1:0] map_y;
		logic             end_of_frame;
	} meta_t;

endpackage

### rtl/f9csm_score.sv
// ring differences, arc minima (registered) and final score selection
module f9csm_score import f9csm_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  win_t       win,
	input  pix_t       threshold,
	output pix_t       score
);

	pix_t bright [RING_N];
	pix_t dark   [RING_N];
	pix_t arc_b  [RING_N];
	pix_t arc_d  [RING_N];
	pix_t arc_s3 [2*RING_N];

	// differences to the centre, clamped at zero, and min over each 9-pixel arc
	always_comb begin
		pix_t       p;
		pix_t       v;
		logic [3:0] idx;
		p = win[3][3];
		for (int i = 0; i < RING_N; i++) begin
			v = win[3 + RING_DY[i]][3 + RING_DX[i]];
			bright[i] = (v > p) ? v - p : '0;
			dark[i]   = (p > v) ? p - v : '0;
		end
		for (int s = 0; s < RING_N; s++) begin
			arc_b[s] = bright[s];
			arc_d[s] = dark[s];
			for (int k = 1; k < ARC_LEN; k++) begin
				idx = 4'(s + k);
				if (bright[idx] < arc_b[s]) arc_b[s] = bright[idx];
				if (dark[idx] < arc_d[s]) arc_d[s] = dark[idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < RING_N; s++) begin
				arc_s3[s]          <= arc_b[s];
				arc_s3[s + RING_N] <= arc_d[s];
			end
		end
	end

	// max tree over the 32 arc minima of both polarities
	always_comb begin
		pix_t l1 [16];
		pix_t l2 [8];
		pix_t l3 [4];
		pix_t l4 [2];
		pix_t best;
		for (int i = 0; i < 16; i++)
			l1[i] = (arc_s3[2*i] > arc_s3[2*i+1]) ? arc_s3[2*i] : arc_s3[2*i+1];
		for (int i = 0; i < 8; i++)
			l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
		for (int i = 0; i < 4; i++)
			l3[i] = (l2[2*i] > l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
		for (int i = 0; i < 2; i++)
			l4[i] = (l3[2*i] > l3[2*i+1]) ? l3[2*i] : l3[2*i+1];
		best  = (l4[0] > l4[1]) ? l4[0] : l4[1];
		score = (best > threshold) ? best - 8'd1 : NO_CORNER;
	end

endmodule

### rtl/fast9_corner_score_map.sv
// top level of the fast-9 corner score map
// Streams an 8-bit grey image in raster order, one pixel per transaction, and
// emits one result transaction for every interior centre (column and row
// 3..size-4) with its FAST-9 score minus one, or 255 when the score does not
// exceed the threshold. One pixel is taken per clock while in_ready is high; a
// result passes the line store read, the window update, the arc minima and the
// max tree into the output register after the pixel that completes its 7x7
// window. The input keeps flowing while a result waits in the output register,
// as long as the internal stages have room. The user writes registers over the
// cfg channel only while the stream is idle; the block itself does not enforce
// this. cfg_ready is always high and writes to an unused index are dropped.
module fast9_corner_score_map import f9csm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel stream
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 start_of_frame,
	// score stream
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COL_W-1:0]     map_x,
	output logic [ROW_W-1:0]     map_y,
	output logic [PIX_W-1:0]     score,
	output logic                 end_of_frame,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// configuration registers
	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	pix_t             threshold_q;

	// raster position
	logic [COL_W-1:0] col_cnt_q;
	logic [ROW_W-1:0] row_cnt_q;

	// six previous rows per column, oldest in the low byte
	logic [LINE_W-1:0] line_mem [MAX_WIDTH];
	logic [LINE_W-1:0] line_rd_q;
	logic [LINE_W-1:0] last_wr_q;

	win_t window_q;

	// stage 1: line store data available
	logic              s1_v;
	pix_t              pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              fwd_s1;
	logic              res_s1;
	meta_t             meta_s1;
	// stage 2: window holds the item
	logic              s2_v;
	meta_t             meta_s2;
	// stage 3: arc minima registered
	logic              s3_v;
	meta_t             meta_s3;
	// output register
	logic              out_valid_q;
	meta_t             meta_q;
	pix_t              score_q;

	logic              accept, cfg_fire;
	logic              s1_fire, s2_free, s3_free, o_free;
	logic [FW_W-1:0]   w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic [COL_W-1:0]  c0, c_nxt;
	logic [ROW_W-1:0]  r0, r_nxt;
	logic [FW_W-1:0]   c_inc;
	logic [ROW_W:0]    r_inc;
	logic              has_res;
	meta_t             meta_in;
	logic [LINE_W-1:0] col_data;
	logic [LINE_W-1:0] wr_data;
	pix_t              score_c;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= ROW_W'(480);
			threshold_q    <= PIX_W'(20);
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_THRESHOLD:    threshold_q    <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	// each stage moves when the one after it is empty or moving too
	assign o_free   = !out_valid_q || out_ready;
	assign s3_free  = !s3_v || o_free;
	assign s2_free  = !s2_v || s3_free;
	assign s1_fire  = s1_v && s2_free;
	assign in_ready = !s1_v || s2_free;
	assign accept   = in_valid && in_ready;

	// -------------------------------------------------- position and border
	always_comb begin
		// width clamped to 1..MAX_WIDTH, height zero acts as one
		if (frame_width_q == '0)
			w_eff = FW_W'(1);
		else if (frame_width_q > FW_W'(MAX_WIDTH))
			w_eff = FW_W'(MAX_WIDTH);
		else
			w_eff = frame_width_q;
		h_eff = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;

		c0 = start_of_frame ? '0 : col_cnt_q;
		r0 = start_of_frame ? '0 : row_cnt_q;

		has_res = (c0 >= COL_W'(6)) && (r0 >= ROW_W'(6)) &&
		          ({1'b0, c0} < w_eff) && (r0 < h_eff);
		meta_in.map_x        = c0 - COL_W'(3);
		meta_in.map_y        = r0 - ROW_W'(3);
		meta_in.end_of_frame = ({1'b0, c0} == w_eff - FW_W'(1)) &&
		                       (r0 == h_eff - ROW_W'(1));

		// wrap after the last column, and after the last row
		c_inc = {1'b0, c0} + FW_W'(1);
		r_inc = {1'b0, r0} + (ROW_W+1)'(1);
		if (c_inc >= w_eff) begin
			c_nxt = '0;
			r_nxt = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
		end else begin
			c_nxt = c_inc[COL_W-1:0];
			r_nxt = r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			col_cnt_q <= c_nxt;
			row_cnt_q <= r_nxt;
		end
	end

	// ------------------------------------------------------------ line store
	// read at accept; write back when the item leaves stage 1. With a one
	// pixel wide frame the next read hits the entry being written, so that
	// case takes the write data from last_wr_q instead
	assign col_data = fwd_s1 ? last_wr_q : line_rd_q;
	assign wr_data  = {pix_s1, col_data[LINE_W-1:PIX_W]};

	always_ff @(posedge clk) begin
		if (accept)
			line_rd_q <= line_mem[c0];
		if (s1_fire) begin
			line_mem[col_s1] <= wr_data;
			last_wr_q        <= wr_data;
		end
	end

	// --------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v <= 1'b0;
		else if (in_ready)
			s1_v <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			col_s1  <= c0;
			fwd_s1  <= s1_fire && (col_s1 == c0);
			res_s1  <= has_res;
			meta_s1 <= meta_in;
		end
	end

	// ---------------------------------------------------------------- window
	// shift left one column and bring in the new column, newest row at bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_fire) begin
			for (int i = 0; i < WIN; i++)
				for (int j = 0; j < WIN-1; j++)
					window_q[i][j] <= window_q[i][j+1];
			for (int i = 0; i < LINES; i++)
				window_q[i][WIN-1] <= col_data[PIX_W*i +: PIX_W];
			window_q[WIN-1][WIN-1] <= pix_s1;
		end
	end

	// ------------------------------------------------------- stages 2 and 3
	// border pixels leave the pipe once they have updated the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v        <= 1'b0;
			s3_v        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_free) s2_v        <= s1_fire && res_s1;
			if (s3_free) s3_v        <= s2_v;
			if (o_free)  out_valid_q <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s2_free) meta_s2 <= meta_s1;
		if (s2_v && s3_free)    meta_s3 <= meta_s2;
		if (s3_v && o_free) begin
			meta_q  <= meta_s3;
			score_q <= score_c;
		end
	end

	f9csm_score u_score (
		.clk       (clk),
		.en        (s2_v && s3_free),
		.win       (window_q),
		.threshold (threshold_q),
		.score     (score_c)
	);

	// ---------------------------------------------------------------- output
	assign out_valid    = out_valid_q;
	assign map_x        = meta_q.map_x;
	assign map_y        = meta_q.map_y;
	assign end_of_frame = meta_q.end_of_frame;
	assign score        = score_q;

endmodule

### sim/tb_fast9_corner_score_map.sv
// self-checking testbench for the fast-9 corner score map, with its own scoring predictor
module tb_fast9_corner_score_map;
	timeunit 1ns;
	timeprecision 1ps;

	import f9csm_pkg::*;

	// writes to this index have no register behind them and must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// output register sits behind the line store, window and arc minima stages, keep some margin
	localparam int SETTLE_CYCLES  = 12;
	// cycles without any transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HALF           = WIN / 2;

	typedef struct packed {
		pix_t pix;
		logic sof;
	} pixel_item_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		pix_t             score;
		logic             eof;
	} corner_rec_t;

	logic                 clk;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel          = '0;
	logic                 start_of_frame = 1'b0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [COL_W-1:0]     map_x;
	logic [ROW_W-1:0]     map_y;
	logic [PIX_W-1:0]     score;
	logic                 end_of_frame;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index      = REG_FRAME_WIDTH;
	logic [CFG_DAT_W-1:0] cfg_data       = '0;

	fast9_corner_score_map DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel         (pixel),
		.start_of_frame(start_of_frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.map_x         (map_x),
		.map_y         (map_y),
		.score         (score),
		.end_of_frame  (end_of_frame),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// pixels waiting to be sent, and scores waiting to come back
	pixel_item_t pixel_q [$];
	corner_rec_t corner_q [$];

	// handshake flags, set at the rising edge and used at the falling edge
	bit in_fire, out_fire, cfg_fire;

	int unsigned pixels_queued, pixels_taken;
	int unsigned mismatch_cnt, idle_cycles;

	// ------------------------------------------------------------------
	// scoring predictor: its own register copies, line store and window
	// ------------------------------------------------------------------
	logic [FW_W-1:0]   pred_width  = 12'd640;
	logic [ROW_W-1:0]  pred_height = 16'd480;
	pix_t              pred_thr    = 8'd20;
	bit [LINE_W-1:0]   line_mem [MAX_WIDTH];
	bit [PIX_W-1:0]    win [WIN][WIN];      // [row][col], row 0 oldest, col 6 newest
	int unsigned       col_pos, row_pos;

	// column offset of ring pixel i, clockwise from the top; the row offset
	// is the same circle turned a quarter, i.e. ring_dx((i + 12) % 16)
	function automatic int ring_dx(input int i);
		case (i)
			0, 8:      return 0;
			1, 7:      return 1;
			2, 6:      return 2;
			3, 4, 5:   return 3;
			9, 15:     return -1;
			10, 14:    return -2;
			default:   return -3;
		endcase
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		case (idx)
			REG_FRAME_WIDTH:  pred_width  = data[FW_W-1:0];
			REG_FRAME_HEIGHT: pred_height = data[ROW_W-1:0];
			REG_THRESHOLD:    pred_thr    = data[PIX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_corner(input pix_t pix, input logic sof);
		int unsigned w, h, c, r, p, v, m, best;
		int unsigned diff [RING_N];
		bit [LINE_W-1:0] colw;
		corner_rec_t rec;
		// out-of-range sizes act as the nearest legal one
		w = (pred_width == 0) ? 1 : ((pred_width > MAX_WIDTH) ? MAX_WIDTH : pred_width);
		h = (pred_height == 0) ? 1 : pred_height;
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		// shift the window left, bring in the stored column plus the new pixel
		colw = line_mem[c];
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j + 1];
		end
		for (int i = 0; i < LINES; i++) win[i][WIN-1] = colw[PIX_W*i +: PIX_W];
		win[WIN-1][WIN-1] = pix;
		line_mem[c] = {pix, colw[LINE_W-1:PIX_W]};

		if (c >= WIN - 1 && r >= WIN - 1 && c < w && r < h) begin
			p = win[HALF][HALF];
			best = 0;
			// bright polarity first, then dark
			for (int pol = 0; pol < 2; pol++) begin
				for (int i = 0; i < RING_N; i++) begin
					v = win[HALF + ring_dx((i + 12) % RING_N)][HALF + ring_dx(i)];
					if (pol == 0) diff[i] = (v > p) ? v - p : 0;
					else diff[i] = (p > v) ? p - v : 0;
				end
				for (int s = 0; s < RING_N; s++) begin
					m = 255;
					for (int k = 0; k < ARC_LEN; k++) begin
						if (diff[(s + k) % RING_N] < m) m = diff[(s + k) % RING_N];
					end
					if (m > best) best = m;
				end
			end
			rec.x     = COL_W'(c - HALF);
			rec.y     = ROW_W'(r - HALF);
			rec.score = (best > pred_thr) ? PIX_W'(best - 1) : NO_CORNER;
			rec.eof   = (c == w - 1 && r == h - 1);
			corner_q.push_back(rec);
		end

		// counters wrap at the current frame size, also when already past it
		c = c + 1;
		if (c >= w) begin
			c = 0;
			r = r + 1;
			if (r >= h) r = 0;
		end
		col_pos = c % (1 << COL_W);
		row_pos = r % (1 << ROW_W);
	endtask

	// ------------------------------------------------------------------
	// monitor: every transaction of the three channels, at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : observe
		corner_rec_t want;
		in_fire  = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (cfg_fire) apply_reg(cfg_index, cfg_data);
		if (out_fire) begin
			if (corner_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected score transaction: x %0d y %0d score %0d eof %0d",
						map_x, map_y, score, end_of_frame);
			end else begin
				want = corner_q.pop_front();
				if (map_x !== want.x || map_y !== want.y || score !== want.score ||
				    end_of_frame !== want.eof) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("score mismatch (exp/got): x %0d/%0d y %0d/%0d score %0d/%0d eof %0d/%0d",
							want.x, map_x, want.y, map_y, want.score, score, want.eof, end_of_frame);
				end
			end
		end
		if (in_fire) begin
			predict_corner(pixel, start_of_frame);
			pixels_taken++;
		end
		idle_cycles = (in_fire || out_fire || cfg_fire) ? 0 : idle_cycles + 1;
	end

	// ------------------------------------------------------------------
	// pixel driver: bursts of random length, random gaps, and now and then
	// a hold until every outstanding score has come back
	// ------------------------------------------------------------------
	int unsigned burst_left = 16;
	int unsigned gap_left   = 0;
	bit          hold_drain = 1'b0;

	always @(negedge clk) begin : feed
		logic        nv;
		pixel_item_t nxt;
		nxt.pix = pixel;
		nxt.sof = start_of_frame;
		// a pixel not yet taken stays on the bus unchanged
		nv = in_valid && !in_fire;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!nv) begin
			if (hold_drain) begin
				if (corner_q.size() == 0) hold_drain = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pixel_q.size() > 0) begin
				nxt = pixel_q.pop_front();
				nv  = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					// half of the bursts run straight into the next one
					gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
					hold_drain = ($urandom_range(0, 15) == 0);
				end
			end
		end
		in_valid       <= nv;
		pixel          <= nxt.pix;
		start_of_frame <= nxt.sof;
	end

	// ------------------------------------------------------------------
	// score receiver: stalls follow a repeating 16-bit pattern that is redrawn from four kinds
	// ------------------------------------------------------------------
	logic [15:0] stall_pat  = 16'hFFFF;
	logic [3:0]  stall_pos  = '0;
	int unsigned stall_left = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;                 // never stall
				1: stall_pat = 16'($urandom) | 16'h0001; // random, never stuck low
				2: stall_pat = 16'hEEEE;                 // three of every four pattern bits ready
				default: stall_pat = 16'h8001;           // long stalls
			endcase
			stall_left = 64;
		end
		out_ready <= arst_n && stall_pat[stall_pos];
		stall_pos++;
		stall_left--;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_pixel(input pix_t v, input logic sof);
		pixel_item_t it;
		it.pix = v;
		it.sof = sof;
		pixel_q.push_back(it);
		pixels_queued++;
	endtask

	// picture styles: uniform noise, low contrast, binary, sparse peaks
	function automatic pix_t gen_pixel(input int style, input int base);
		int v;
		case (style)
			0: v = $urandom_range(0, 255);
			1: v = base + int'($urandom_range(0, 40)) - 20;
			2: v = $urandom_range(0, 1) ? 255 : 0;
			default: v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255)) : base;
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return pix_t'(v);
	endfunction

	// 7x7 frame: centre pixel, ring pixels set in arc_mask get hi, all else lo
	task automatic push_ring_frame(input pix_t centre, input pix_t hi, input pix_t lo,
	                               input logic [RING_N-1:0] arc_mask);
		pix_t v;
		for (int row = 0; row < WIN; row++) begin
			for (int col = 0; col < WIN; col++) begin
				v = (row == HALF && col == HALF) ? centre : lo;
				for (int i = 0; i < RING_N; i++) begin
					if (ring_dx(i) == col - HALF && ring_dx((i + 12) % RING_N) == row - HALF)
						v = arc_mask[i] ? hi : lo;
				end
				push_pixel(v, row == 0 && col == 0);
			end
		end
	endtask

	task automatic push_rows(input int unsigned n, input int style, input int base, input logic sof);
		for (int unsigned i = 0; i < n; i++) push_pixel(gen_pixel(style, base), sof && i == 0);
	endtask

	// registers only change with the stream idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	// every pixel taken, every score back, then let the pipeline settle
	task automatic wait_idle();
		while (pixels_taken != pixels_queued || corner_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// hang guard
	// ------------------------------------------------------------------
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb_fast9_corner_score_map: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned w, h, thr, style, base, rand_pixels;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// a write to the spare index must leave the reset height and threshold in place
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(REG_FRAME_WIDTH, 16'd7);
		push_rows(7 * 7, 0, 0, 1'b1);
		wait_idle();

		// hand-built 7x7 frames: one centre each, eof on every score
		write_reg(REG_FRAME_WIDTH, 16'h7007);
		write_reg(REG_FRAME_HEIGHT, 16'd7);
		write_reg(REG_THRESHOLD, 16'h0000);
		push_ring_frame(8'd255, 8'd0, 8'd0, 16'h0000);     // dark, full contrast
		push_ring_frame(8'd50, 8'd150, 8'd50, 16'h01FF);   // arc of exactly nine
		push_ring_frame(8'd50, 8'd150, 8'd50, 16'h00FF);   // arc of eight only
		push_ring_frame(8'd50, 8'd150, 8'd50, 16'hF81F);   // arc across the ring start
		push_ring_frame(8'd200, 8'd10, 8'd200, 16'h7FC0);  // dark arc
		wait_idle();
		// score equal to threshold is no corner, one above is
		write_reg(REG_THRESHOLD, 16'h5A64);
		push_ring_frame(8'd100, 8'd200, 8'd200, 16'hFFFF);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'd99);
		push_ring_frame(8'd100, 8'd200, 8'd200, 16'hFFFF);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'hA5FE);
		push_ring_frame(8'd0, 8'd255, 8'd255, 16'hFFFF);
		wait_idle();
		// threshold 255 can never be exceeded
		write_reg(REG_THRESHOLD, 16'hFFFF);
		push_ring_frame(8'd0, 8'd255, 8'd255, 16'hFFFF);
		wait_idle();

		// sizes that give no scores
		write_reg(REG_THRESHOLD, 16'd20);
		write_reg(REG_FRAME_WIDTH, 16'h0FFF);  // acts as the maximum width
		push_rows(30, 0, 0, 1'b1);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'h0000);  // acts as width one
		push_rows(10, 0, 0, 1'b1);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'd7);
		write_reg(REG_FRAME_HEIGHT, 16'h0000); // acts as height one
		push_rows(20, 0, 0, 1'b1);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'd6);
		write_reg(REG_FRAME_HEIGHT, 16'd7);
		push_rows(42, 0, 0, 1'b1);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'd7);
		write_reg(REG_FRAME_HEIGHT, 16'd6);
		push_rows(42, 0, 0, 1'b1);
		wait_idle();

		// three 8x8 frames back to back, only the first flagged
		write_reg(REG_FRAME_WIDTH, 16'd8);
		write_reg(REG_FRAME_HEIGHT, 16'd8);
		push_rows(8 * 8 * 3, 3, 80, 1'b1);
		wait_idle();

		// sizes shrink under a running frame: counters past the edge just wrap
		write_reg(REG_FRAME_WIDTH, 16'd12);
		write_reg(REG_FRAME_HEIGHT, 16'd12);
		write_reg(REG_THRESHOLD, 16'd30);
		push_rows(12 * 9 + 5, 0, 0, 1'b1);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'd9);
		push_rows(21, 0, 0, 1'b0);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 16'd7);     // column now beyond the width
		push_rows(56, 3, 120, 1'b0);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 16'd5);    // row now beyond the height
		push_rows(14, 0, 0, 1'b0);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 16'd9);
		push_rows(63, 3, 60, 1'b0);
		wait_idle();

		// tallest frame, only its top rows
		write_reg(REG_FRAME_WIDTH, 16'hF007);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		write_reg(REG_THRESHOLD, 16'h0000);
		push_rows(7 * 20, 3, 128, 1'b1);
		wait_idle();

		// random frames, each with its own sizes, threshold and picture style
		rand_pixels = 0;
		while (rand_pixels < 150) begin
			w = $urandom_range(7, 14);
			h = $urandom_range(7, 10);
			case ($urandom_range(0, 7))
				0: thr = 255;
				1: thr = 0;
				default: thr = $urandom_range(0, 60);
			endcase
			style = $urandom_range(0, 3);
			base  = $urandom_range(0, 255);
			write_reg(REG_FRAME_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
			write_reg(REG_FRAME_HEIGHT, 16'(h));
			write_reg(REG_THRESHOLD, {8'($urandom), 8'(thr)});
			for (int unsigned n = 0; n < w * h; n++) begin
				// a stray frame start now and then breaks the sequence
				push_pixel(gen_pixel(style, base), n == 0 || $urandom_range(0, 199) == 0);
			end
			rand_pixels += w * h;
			// sometimes a partial frame follows without a frame start
			if ($urandom_range(0, 3) == 0) push_rows($urandom_range(1, 20), style, base, 1'b0);
			wait_idle();
		end

		if (mismatch_cnt == 0) begin
			$display("tb_fast9_corner_score_map: clean");
		end else begin
			$display("tb_fast9_corner_score_map: errors");
		end
		$finish;
	end

endmodule
